FILE: rtl/prrs_pkg.sv
// Shared constants, control word type and microcode program for the permutation rank block.
`timescale 1ns / 1ps
`default_nettype none

package prrs_pkg;

	// Field widths.
	localparam int LEN_W  = 18;
	localparam int STEP_W = 20;
	localparam int SUM_W  = 34;
	localparam int RANK_W = 41;

	// Permutation length limits and length of the tail that is decoded.
	localparam int MAX_LEN  = 131072;
	localparam int TAIL_LEN = 15;
	localparam int TAIL_W   = $clog2(TAIL_LEN + 1);
	localparam int IDX_W    = $clog2(TAIL_LEN);

	// One factorial digit is below TAIL_LEN, so it is found in QBITS restoring steps.
	localparam int QBITS = $clog2(TAIL_LEN);
	localparam int K_W   = (QBITS > 1) ? $clog2(QBITS) : 1;
	localparam int DIV_W = RANK_W + QBITS - 1;

	// Bus widths, padded to whole bytes.
	localparam int IN_BITS  = 2 * LEN_W + STEP_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = SUM_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// k! for k = 0 .. TAIL_LEN.
	localparam logic [RANK_W-1:0] FACT_TAB [TAIL_LEN+1] = '{
		41'd1, 41'd1, 41'd2, 41'd6, 41'd24, 41'd120, 41'd720, 41'd5040,
		41'd40320, 41'd362880, 41'd3628800, 41'd39916800, 41'd479001600,
		41'd6227020800, 41'd87178291200, 41'd1307674368000
	};

	// Microcode: datapath actions.
	localparam int ACT_W = 4;
	localparam logic [ACT_W-1:0] ACT_NONE  = 4'd0;
	localparam logic [ACT_W-1:0] ACT_FETCH = 4'd1;
	localparam logic [ACT_W-1:0] ACT_SETUP = 4'd2;
	localparam logic [ACT_W-1:0] ACT_TRIB  = 4'd3;
	localparam logic [ACT_W-1:0] ACT_TRIA  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_DIV   = 4'd5;
	localparam logic [ACT_W-1:0] ACT_PICK  = 4'd6;
	localparam logic [ACT_W-1:0] ACT_OUT   = 4'd7;
	localparam logic [ACT_W-1:0] ACT_ADV   = 4'd8;

	// Microcode: jump conditions.
	localparam int CND_W = 3;
	localparam logic [CND_W-1:0] CND_NEVER       = 3'd0;
	localparam logic [CND_W-1:0] CND_ALWAYS      = 3'd1;
	localparam logic [CND_W-1:0] CND_NO_IN       = 3'd2;
	localparam logic [CND_W-1:0] CND_IS_ADV      = 3'd3;
	localparam logic [CND_W-1:0] CND_NO_TAIL     = 3'd4;
	localparam logic [CND_W-1:0] CND_BITS_LEFT   = 3'd5;
	localparam logic [CND_W-1:0] CND_DIGITS_LEFT = 3'd6;
	localparam logic [CND_W-1:0] CND_OUT_FREE    = 3'd7;

	// Program addresses.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
	localparam logic [PC_W-1:0] PC_SETUP = 4'd1;
	localparam logic [PC_W-1:0] PC_TRIB  = 4'd2;
	localparam logic [PC_W-1:0] PC_TRIA  = 4'd3;
	localparam logic [PC_W-1:0] PC_DIV   = 4'd4;
	localparam logic [PC_W-1:0] PC_PICK  = 4'd5;
	localparam logic [PC_W-1:0] PC_OUT   = 4'd6;
	localparam logic [PC_W-1:0] PC_WAIT  = 4'd7;
	localparam logic [PC_W-1:0] PC_ADV   = 4'd8;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [CND_W-1:0] cnd;
		logic [PC_W-1:0]  tgt;
	} ctrl_word_t;

	// Program ROM. A word jumps to tgt when its condition holds, else falls through.
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		unique case (pc)
			PC_FETCH: w = '{ACT_FETCH, CND_NO_IN,       PC_FETCH};
			PC_SETUP: w = '{ACT_SETUP, CND_IS_ADV,      PC_ADV};
			PC_TRIB:  w = '{ACT_TRIB,  CND_NEVER,       PC_FETCH};
			PC_TRIA:  w = '{ACT_TRIA,  CND_NO_TAIL,     PC_OUT};
			PC_DIV:   w = '{ACT_DIV,   CND_BITS_LEFT,   PC_DIV};
			PC_PICK:  w = '{ACT_PICK,  CND_DIGITS_LEFT, PC_DIV};
			PC_OUT:   w = '{ACT_OUT,   CND_OUT_FREE,    PC_FETCH};
			PC_WAIT:  w = '{ACT_NONE,  CND_ALWAYS,      PC_OUT};
			PC_ADV:   w = '{ACT_ADV,   CND_ALWAYS,      PC_FETCH};
			default:  w = '{ACT_NONE,  CND_ALWAYS,      PC_FETCH};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/permutation_rank_range_sum.sv
// Top level: range sums over a permutation kept as a lexicographic rank, decoded by a microcoded sequencer.
`timescale 1ns / 1ps
`default_nettype none

// The block holds the lexicographic rank of a permutation of 1..n, where n comes from the
// seq_length register (0 reads as 1, values above 131072 read as 131072) and reset gives rank 0,
// the identity. An advance transfer (tuser high) adds step to the rank, clamps it at T!-1 with
// T = min(n, 15), sets the sticky saturation flag when it clamps, and produces no output. A
// query transfer (tuser low) returns the sum of the values at positions left..right, after left 0
// is read as 1 and right is clipped to n; an empty range gives 0. Control is a nine-word program
// in a read-only table that steps one plain datapath. An advance runs the fetch, setup and
// advance steps. A query runs fetch, setup and two triangular-number steps; if its range reaches
// the last T positions, each of the T factorial-base digits is then found by four restoring
// compare-and-subtract steps on one shared 44-bit subtractor, followed by one step that removes
// the chosen value from the pool and adds it to the sum when its position is in the range. The
// result sits in an output register, so the next item is taken while it waits to be read. The
// configuration port is always ready and must be written only while the block is idle.
module permutation_rank_range_sum (
	input  wire                          clk,
	input  wire                          arst_n,
	// Configuration: seq_length.
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [prrs_pkg::LEN_W-1:0]   cfg_data,
	// Input stream. tdata from bit 0: left[17:0], right[35:18], step[55:36].
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [prrs_pkg::IN_W-1:0]    s_tdata,
	input  wire                          s_tuser,   // op: 0 query, 1 advance
	// Output stream. tdata from bit 0: range_sum[33:0], rank_saturated[34], zero pad.
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [prrs_pkg::OUT_W-1:0]   m_tdata
);

	localparam int LW = prrs_pkg::LEN_W;
	localparam int RW = prrs_pkg::RANK_W;
	localparam int SW = prrs_pkg::SUM_W;
	localparam int IW = prrs_pkg::IDX_W;
	localparam int TW = prrs_pkg::TAIL_W;
	localparam int DW = prrs_pkg::DIV_W;
	localparam int KW = prrs_pkg::K_W;
	localparam int QB = prrs_pkg::QBITS;
	localparam int TL = prrs_pkg::TAIL_LEN;

	// Length derived at configuration time: n, tail length T and head length n - T.
	logic [LW-1:0] n_q, head_q;
	logic [TW-1:0] t_q;
	logic [LW-1:0] cfg_n, cfg_head;
	logic [TW-1:0] cfg_t;

	// Sequencer.
	logic [prrs_pkg::PC_W-1:0] pc_q, pc_n;
	prrs_pkg::ctrl_word_t      uw;
	logic                      jump;

	// Item and working registers.
	logic                      op_q;
	logic [LW-1:0]             lo_q, hi_q, a_q, b_q;
	logic [prrs_pkg::STEP_W-1:0] step_q;
	logic                      tail_on_q;
	logic [IW-1:0]             tlo_q, thi_q, d_q, i_q, qt_q;
	logic [KW-1:0]             k_q;
	logic [RW-1:0]             rem_q, rank_q;
	logic                      sat_q;
	logic [SW-1:0]             acc_q;
	logic [IW-1:0]             pool_q [TL];
	logic                      m_tvalid_q;
	logic [SW:0]               m_data_q;

	// Combinational datapath.
	logic [LW-1:0]  lo_c, hi_c, lo_m1, a_c, b_c, tlo_d, thi_d, pick_val;
	logic           empty_c, tail_on_c, out_free, ge, in_rng;
	logic [RW-1:0]  maxr, rank_clip, fact_d;
	logic [RW:0]    adv_sum;
	logic [LW-1:0]  mul_x;
	logic [2*LW+1:0] mul_p;
	logic [SW-1:0]  tri_v;
	logic [DW-1:0]  div_sh, div_rem;
	logic [IW-1:0]  q_c;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_n = LW'(1);
		end else if (cfg_data > LW'(prrs_pkg::MAX_LEN)) begin
			cfg_n = LW'(prrs_pkg::MAX_LEN);
		end else begin
			cfg_n = cfg_data;
		end
		cfg_t    = (cfg_n < LW'(TL)) ? cfg_n[TW-1:0] : TW'(TL);
		cfg_head = cfg_n - LW'(cfg_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= LW'(1);
			t_q    <= TW'(1);
			head_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			n_q    <= cfg_n;
			t_q    <= cfg_t;
			head_q <= cfg_head;
		end
	end

	// Program ROM lookup and jump decision.
	assign uw       = prrs_pkg::ucode(pc_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (uw.act == prrs_pkg::ACT_FETCH);

	always_comb begin
		unique case (uw.cnd)
			prrs_pkg::CND_NEVER:       jump = 1'b0;
			prrs_pkg::CND_ALWAYS:      jump = 1'b1;
			prrs_pkg::CND_NO_IN:       jump = !s_tvalid;
			prrs_pkg::CND_IS_ADV:      jump = op_q;
			prrs_pkg::CND_NO_TAIL:     jump = !tail_on_q;
			prrs_pkg::CND_BITS_LEFT:   jump = (k_q != '0);
			prrs_pkg::CND_DIGITS_LEFT: jump = (d_q != '0);
			prrs_pkg::CND_OUT_FREE:    jump = out_free;
			default:                   jump = 1'b0;
		endcase
		pc_n = jump ? uw.tgt : pc_q + prrs_pkg::PC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= prrs_pkg::PC_FETCH;
		end else begin
			pc_q <= pc_n;
		end
	end

	// Range clipping and the split into head part and tail part.
	always_comb begin
		lo_c      = (lo_q == '0) ? LW'(1) : lo_q;
		hi_c      = (hi_q > n_q) ? n_q : hi_q;
		empty_c   = lo_c > hi_c;
		lo_m1     = lo_c - LW'(1);
		a_c       = empty_c ? '0 : ((lo_m1 < head_q) ? lo_m1 : head_q);
		b_c       = empty_c ? '0 : ((hi_c < head_q) ? hi_c : head_q);
		tail_on_c = !empty_c && (hi_c > head_q);
		tlo_d     = (lo_c > head_q) ? (lo_c - head_q - LW'(1)) : '0;
		thi_d     = hi_c - head_q - LW'(1);
		maxr      = prrs_pkg::FACT_TAB[t_q] - RW'(1);
		rank_clip = (rank_q > maxr) ? maxr : rank_q;
		adv_sum   = {1'b0, rank_q} + (RW + 1)'(step_q);
	end

	// Shared multiplier for the triangular numbers x(x+1)/2. The upper operand bits are
	// zero, so the product array is only 18 by 19 bits.
	always_comb begin
		mul_x = (uw.act == prrs_pkg::ACT_TRIB) ? b_q : a_q;
		mul_p = (2*LW+2)'(mul_x) * ((2*LW+2)'(mul_x) + (2*LW+2)'(1));
		tri_v = mul_p[SW:1];
	end

	// One restoring step of the digit division: compare against d! shifted by the bit weight.
	always_comb begin
		fact_d  = prrs_pkg::FACT_TAB[d_q];
		div_sh  = DW'(fact_d) << k_q;
		ge      = DW'(rem_q) >= div_sh;
		div_rem = DW'(rem_q) - div_sh;
	end

	// Digit pick: the quotient selects an unused tail value; the clamp only guards bad digits.
	always_comb begin
		q_c      = (qt_q > d_q) ? d_q : qt_q;
		pick_val = head_q + LW'(pool_q[q_c]) + LW'(1);
		in_rng   = (i_q >= tlo_q) && (i_q <= thi_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
			sat_q  <= 1'b0;
		end else if (uw.act == prrs_pkg::ACT_ADV) begin
			if (adv_sum > {1'b0, maxr}) begin
				rank_q <= maxr;
				sat_q  <= 1'b1;
			end else begin
				rank_q <= adv_sum[RW-1:0];
			end
		end
	end

	// Working registers carry payload only and need no reset.
	always_ff @(posedge clk) begin
		unique case (uw.act)
			prrs_pkg::ACT_FETCH: begin
				if (s_tvalid) begin
					op_q   <= s_tuser;
					lo_q   <= s_tdata[LW-1:0];
					hi_q   <= s_tdata[2*LW-1:LW];
					step_q <= s_tdata[2*LW+prrs_pkg::STEP_W-1:2*LW];
				end
			end
			prrs_pkg::ACT_SETUP: begin
				a_q       <= a_c;
				b_q       <= b_c;
				tail_on_q <= tail_on_c;
				tlo_q     <= tlo_d[IW-1:0];
				thi_q     <= thi_d[IW-1:0];
				rem_q     <= rank_clip;
				d_q       <= IW'(t_q - TW'(1));
				i_q       <= '0;
				k_q       <= KW'(QB - 1);
				qt_q      <= '0;
				for (int j = 0; j < TL; j++) begin
					pool_q[j] <= IW'(j);
				end
			end
			prrs_pkg::ACT_TRIB: begin
				acc_q <= tri_v;
			end
			prrs_pkg::ACT_TRIA: begin
				acc_q <= acc_q - tri_v;
			end
			prrs_pkg::ACT_DIV: begin
				if (ge) begin
					rem_q      <= div_rem[RW-1:0];
					qt_q[k_q]  <= 1'b1;
				end
				k_q <= k_q - KW'(1);
			end
			prrs_pkg::ACT_PICK: begin
				if (in_rng) begin
					acc_q <= acc_q + SW'(pick_val);
				end
				for (int j = 0; j < TL - 1; j++) begin
					if (IW'(j) >= q_c) begin
						pool_q[j] <= pool_q[j+1];
					end
				end
				i_q  <= i_q + IW'(1);
				d_q  <= d_q - IW'(1);
				k_q  <= KW'(QB - 1);
				qt_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded by the program, drained by the downstream handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((uw.act == prrs_pkg::ACT_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((uw.act == prrs_pkg::ACT_OUT) && out_free) begin
			m_data_q <= {sat_q, acc_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = prrs_pkg::OUT_W'(m_data_q);

	// The clipped rank is below (d+1)!, so every digit fits in the remaining pool.
	a_digit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.act == prrs_pkg::ACT_PICK) |-> (qt_q <= d_q))
		else $error("factorial digit exceeds remaining pool");

	// After the restoring steps the remainder is below the digit's factorial.
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.act == prrs_pkg::ACT_PICK) |-> (rem_q < prrs_pkg::FACT_TAB[d_q]))
		else $error("division remainder not reduced");

	// The saturation flag is sticky until reset.
	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(sat_q))
		else $error("saturation flag cleared");

	// A result appears only from the output step of the program.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(uw.act == prrs_pkg::ACT_OUT))
		else $error("result raised outside output step");

endmodule

`default_nettype wire

FILE: tb/range_sum_checker.sv
// Checker that follows the permutation rank from observed transfers and checks every range sum and saturation flag.
`timescale 1ns / 1ps
`default_nettype none

module range_sum_checker
	import prrs_pkg::*;
#(
	parameter logic ADVANCE_OP = 1'b1
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_valid,
	input  wire              cfg_ready,
	input  wire  [LEN_W-1:0] cfg_data,
	input  wire              s_tvalid,
	input  wire              s_tready,
	input  wire  [IN_W-1:0]  s_tdata,
	input  wire              s_tuser,
	input  wire              m_tvalid,
	input  wire              m_tready,
	input  wire  [OUT_W-1:0] m_tdata,
	output int               fail_count,
	output int               open_queries
);

	typedef struct packed {
		logic [SUM_W-1:0] range_sum;
		logic             rank_saturated;
	} sum_result_t;

	sum_result_t      awaited_sums[$];
	logic [LEN_W-1:0] length_reg;
	longint unsigned  perm_position;
	logic             clamp_seen;
	int               errs;

	function automatic longint unsigned factorial(input longint unsigned k);
		longint unsigned f;
		longint unsigned i;
		f = 1;
		for (i = 2; i <= k; i++) begin
			f = f * i;
		end
		return f;
	endfunction

	function automatic longint unsigned triangle(input longint unsigned x);
		return (x * (x + 1)) / 2;
	endfunction

	function automatic longint unsigned live_length();
		longint unsigned n;
		n = longint'(length_reg);
		if (n == 0) n = 1;
		if (n > MAX_LEN) n = MAX_LEN;
		return n;
	endfunction

	function automatic longint unsigned tail_size(input longint unsigned n);
		return (n < TAIL_LEN) ? n : TAIL_LEN;
	endfunction

	// Sum over positions lo..hi of the permutation at the current rank.
	function automatic logic [SUM_W-1:0] predict_range_sum(input longint unsigned lo_in,
			input longint unsigned hi_in);
		longint unsigned n, t, head, lo, hi, a, b, total, rank, f, q, avail;
		longint unsigned i, j, p;
		longint unsigned pool [TAIL_LEN];
		longint unsigned tail_val [TAIL_LEN];
		n = live_length();
		t = tail_size(n);
		head = n - t;
		lo = (lo_in == 0) ? 1 : lo_in;
		hi = (hi_in > n) ? n : hi_in;
		if (lo > hi) return '0;
		a = (lo - 1 < head) ? lo - 1 : head;
		b = (hi < head) ? hi : head;
		total = triangle(b) - triangle(a);
		if (hi > head) begin
			rank = perm_position;
			if (rank > factorial(t) - 1) rank = factorial(t) - 1;
			for (i = 0; i < t; i++) begin
				pool[i] = head + 1 + i;
			end
			avail = t;
			// Each factorial-base digit picks one of the values still unused.
			for (i = 0; i < t; i++) begin
				f = factorial(t - 1 - i);
				q = rank / f;
				if (q >= avail) q = avail - 1;
				tail_val[i] = pool[q];
				for (j = q; j + 1 < avail; j++) begin
					pool[j] = pool[j + 1];
				end
				avail--;
				rank = rank % f;
			end
			for (p = (lo > head) ? lo : head + 1; p <= hi; p++) begin
				total += tail_val[p - head - 1];
			end
		end
		return total[SUM_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sum_result_t     got, want;
		longint unsigned top_rank, next_rank;
		if (!arst_n) begin
			awaited_sums.delete();
			length_reg    = 1;
			perm_position = 0;
			clamp_seen    = 1'b0;
			errs          = 0;
			fail_count   <= 0;
			open_queries <= 0;
		end else begin
			// Results first, so a result can never be matched with a query taken at the same edge.
			if (m_tvalid && m_tready) begin
				got.range_sum      = m_tdata[SUM_W-1:0];
				got.rank_saturated = m_tdata[SUM_W];
				if (awaited_sums.size() == 0) begin
					errs++;
					$error("result transfer with no query waiting: range_sum %0d", got.range_sum);
				end else begin
					want = awaited_sums.pop_front();
					if (got.range_sum !== want.range_sum) begin
						errs++;
						$error("range_sum: expected %0d, actual %0d",
							want.range_sum, got.range_sum);
					end
					if (got.rank_saturated !== want.rank_saturated) begin
						errs++;
						$error("rank_saturated: expected %0d, actual %0d",
							want.rank_saturated, got.rank_saturated);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				length_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == ADVANCE_OP) begin
					top_rank  = factorial(tail_size(live_length())) - 1;
					next_rank = perm_position + longint'(s_tdata[2*LEN_W+STEP_W-1:2*LEN_W]);
					if (next_rank > top_rank) begin
						next_rank  = top_rank;
						clamp_seen = 1'b1;
					end
					perm_position = next_rank;
				end else begin
					want.range_sum = predict_range_sum(longint'(s_tdata[LEN_W-1:0]),
						longint'(s_tdata[2*LEN_W-1:LEN_W]));
					want.rank_saturated = clamp_seen;
					awaited_sums = {awaited_sums, want};
				end
			end
			fail_count   <= errs;
			open_queries <= awaited_sums.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Top of the testbench: clock, reset, stimulus and verdict for the permutation rank block.
`timescale 1ns / 1ps
`default_nettype none

// The stimulus runs in phases. Each phase first lets the block go idle, then writes a new
// permutation length, and then sends a mix of advance and query transfers. The first phases
// keep the rank below its clamp so that results carry a clear saturation flag; a later phase
// shrinks the length under a large stored rank and then forces the clamp. The lengths cover
// zero, one, two, the tail size and its neighbors, the largest length and values above it,
// up to all ones. Both the sender and the receiver pause in random bursts, except in the
// last phase, which runs with no pauses at all. The checker beside the block predicts every
// result and counts failures; this module only gives the verdict.
module tb_top;
	import prrs_pkg::*;

	localparam logic OP_QUERY   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Idle wait after the last query result, to cover any work still in flight.
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 1000000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [LEN_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tready  = 1'b0;
	wire              cfg_ready;
	wire              s_tready;
	wire              m_tvalid;
	wire  [OUT_W-1:0] m_tdata;

	int               fail_count;
	int               open_queries;
	int               cycle_count = 0;
	int               stall_left  = 0;
	logic             calm        = 1'b0;
	int unsigned      cur_len     = 1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	permutation_rank_range_sum i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // left[17:0], right[35:18], step[55:36]
		.s_tuser   (s_tuser),   // op
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // range_sum[33:0], rank_saturated[34], zero pad
	);

	range_sum_checker #(
		.ADVANCE_OP (OP_ADVANCE)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.open_queries (open_queries)
	);

	// A hung block must not keep the run going forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The receiver stalls in random bursts, with long ready stretches between them, and stays ready in the calm phase.
	always @(posedge clk) begin
		if (calm) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one transfer, sometimes after a gap, and returns at the edge that takes it.
	// tvalid is only lowered before a gap, so it is never dropped and raised in one step.
	task automatic send_item(input logic op, input logic [LEN_W-1:0] lft,
			input logic [LEN_W-1:0] rgt, input logic [STEP_W-1:0] stp);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_W'({stp, rgt, lft});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic query_range(input logic [LEN_W-1:0] lft, input logic [LEN_W-1:0] rgt);
		send_item(OP_QUERY, lft, rgt, STEP_W'($urandom()));
	endtask

	task automatic advance_rank(input logic [STEP_W-1:0] stp);
		send_item(OP_ADVANCE, LEN_W'($urandom()), LEN_W'($urandom()), stp);
	endtask

	// Lowers tvalid, waits for every query result, then lets pending advances finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_queries != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_len = (value == 0) ? 1 : (value > MAX_LEN) ? MAX_LEN : value;
	endtask

	// Most queries land in the decoded tail or straddle its start; the rest probe the edges
	// and raw field values, which are often empty ranges.
	task automatic random_query();
		logic [LEN_W-1:0] lft, rgt;
		int unsigned      tail_lo;
		tail_lo = (cur_len > TAIL_LEN) ? cur_len - TAIL_LEN + 1 : 1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				lft = LEN_W'($urandom_range(tail_lo, cur_len));
				rgt = LEN_W'($urandom_range(lft, cur_len));
			end
			4, 5: begin
				lft = LEN_W'($urandom_range((tail_lo > 4) ? tail_lo - 3 : 1, cur_len));
				rgt = LEN_W'($urandom_range(lft, cur_len));
			end
			6: begin
				lft = LEN_W'($urandom_range(1, cur_len));
				rgt = LEN_W'($urandom_range(lft, cur_len));
			end
			7: begin
				lft = LEN_W'($urandom_range(0, 1));
				rgt = LEN_W'($urandom_range(cur_len, (1 << LEN_W) - 1));
			end
			default: begin
				lft = LEN_W'($urandom());
				rgt = LEN_W'($urandom());
			end
		endcase
		query_range(lft, rgt);
	endtask

	task automatic random_advance();
		case ($urandom_range(0, 9))
			0: advance_rank('0);
			1: advance_rank('1);
			2, 3, 4, 5: advance_rank(STEP_W'($urandom_range(1, 1000)));
			default: advance_rank(STEP_W'($urandom()));
		endcase
	endtask

	task automatic random_items(input int count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 4) begin
				random_advance();
			end else begin
				random_query();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset length of one: any nonzero step would clamp, so only a zero step is sent.
		query_range(1, 1);
		query_range(0, 0);
		query_range(0, '1);
		query_range(2, 3);
		advance_rank('0);
		query_range(1, 1);

		// Largest length: head-only, tail-only, straddling and empty ranges.
		write_length(LEN_W'(MAX_LEN));
		query_range(0, '1);
		query_range(1, LEN_W'(MAX_LEN - TAIL_LEN));
		query_range(LEN_W'(MAX_LEN - TAIL_LEN + 1), LEN_W'(MAX_LEN));
		query_range(LEN_W'(MAX_LEN - TAIL_LEN), LEN_W'(MAX_LEN - TAIL_LEN + 1));
		query_range(LEN_W'(MAX_LEN), LEN_W'(MAX_LEN));
		query_range(100, 99);
		query_range('1, '1);
		advance_rank('1);
		query_range(LEN_W'(MAX_LEN - TAIL_LEN + 1), LEN_W'(MAX_LEN));
		random_items(45);

		write_length(16);
		random_items(40);
		write_length(20);
		random_items(40);
		write_length(LEN_W'($urandom_range(21, 3000)));
		random_items(40);
		// All ones reads as the largest length.
		write_length('1);
		random_items(35);
		write_length(LEN_W'(MAX_LEN + 1));
		query_range(1, '1);
		random_items(35);
		write_length(LEN_W'(TAIL_LEN));
		random_items(40);

		// The stored rank is now far above 5!-1: queries decode with the clamped rank,
		// then the largest step clamps the rank itself and sets the sticky flag.
		write_length(5);
		query_range(1, 5);
		advance_rank('1);
		query_range(3, 5);
		random_items(40);

		// A zero length reads as one.
		write_length(0);
		query_range(1, 1);
		random_items(30);
		write_length(2);
		random_items(40);
		write_length(9);
		random_items(40);
		write_length(LEN_W'(TAIL_LEN - 1));
		random_items(40);

		// Last phase runs with no pauses on either side.
		write_length(LEN_W'(TAIL_LEN + 1));
		calm <= 1'b1;
		random_items(50);

		settle();
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/prrs_pkg.sv
rtl/permutation_rank_range_sum.sv
tb/range_sum_checker.sv
tb/tb_top.sv
